>>> design/qse_pkg.sv
// qse_pkg: word and link types shared by the sorting chain and its cells
// no dependencies

package qse_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] t_value;

    // input word: one element of the set
    typedef struct packed {
        t_value value;
        logic   is_last;
    } t_in_word;

    // output word: one element in ascending order
    typedef struct packed {
        t_value value_res;
        logic   is_last_res;
    } t_out_word;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic   insert;
        logic   shift;
        t_value value;
    } t_ctl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic   full;
        logic   keep;
        t_value val;
    } t_link;

endpackage

>>> design/qse_stream_if.sv
// qse_stream_if: valid/ready channel carrying one word per handshake
// word type comes from qse_pkg through the type parameter

interface qse_stream_if #(
    parameter type t_word = qse_pkg::t_in_word
);
    logic  valid;
    logic  ready;
    t_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/quicksort_engine.sv
// quicksort_engine: top level, load and drain control around the cell chain
// depends on qse_pkg, qse_stream_if and qse_cell

// Sorts sets of up to DEPTH signed 32-bit words in ascending order. Words
// are taken one per cycle while the block is loading; each one is inserted
// in place into a chain of DEPTH cells in the cycle it is accepted, so the
// chain is always sorted. A word with is_last set, or the word that fills
// the chain, ends the set. The block then stops taking input and drains the
// chain from its low end, one word per cycle while the sink is ready,
// marking the greatest word with is_last_res. Loading and draining never
// overlap, as the chain has a single shared insert/shift path. After the
// marked word is taken the next set may load.

module quicksort_engine #(
    parameter int unsigned DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    qse_stream_if.sink   i_in,
    qse_stream_if.source o_out
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        LOAD,
        DRAIN
    } t_mode;

    t_mode            r_mode;
    logic [CNT_W-1:0] r_count;

    qse_pkg::t_ctl  w_ctl;
    qse_pkg::t_link w_link [DEPTH];
    qse_pkg::t_link w_prev [DEPTH];
    qse_pkg::t_link w_next [DEPTH];
    logic           w_in_acc;
    logic           w_out_acc;
    logic           w_set_end;

    assign i_in.ready = (r_mode == LOAD);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_acc  = o_out.valid && o_out.ready;
    assign w_set_end  = i_in.data.is_last || (r_count == CNT_W'(DEPTH - 1));

    assign w_ctl.insert = w_in_acc;
    assign w_ctl.shift  = w_out_acc;
    assign w_ctl.value  = i_in.data.value;

    // head of the chain takes the new word, tail feeds empty slots on shift
    for (genvar g = 0; g < DEPTH; g++) begin : g_chain
        if (g == 0) begin : g_head
            assign w_prev[g] = '{full: 1'b1, keep: 1'b1, val: '0};
        end else begin : g_mid_prev
            assign w_prev[g] = w_link[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_next[g] = '{full: 1'b0, keep: 1'b0, val: '0};
        end else begin : g_mid_next
            assign w_next[g] = w_link[g+1];
        end

        qse_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_prev  (w_prev[g]),
            .i_next  (w_next[g]),
            .o_link  (w_link[g])
        );
    end

    assign o_out.valid            = (r_mode == DRAIN) && w_link[0].full;
    assign o_out.data.value_res   = w_link[0].val;
    assign o_out.data.is_last_res = !w_link[1].full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= LOAD;
            r_count <= '0;
        end else begin
            unique case (r_mode)
                LOAD: begin
                    if (w_in_acc) begin
                        r_count <= r_count + CNT_W'(1);
                        if (w_set_end) begin
                            r_mode <= DRAIN;
                        end
                    end
                end
                DRAIN: begin
                    if (w_out_acc && o_out.data.is_last_res) begin
                        r_mode  <= LOAD;
                        r_count <= '0;
                    end
                end
                default: begin
                    r_mode <= LOAD;
                end
            endcase
        end
    end

endmodule

>>> design/qse_cell.sv
// qse_cell: one slot of the sorted chain, holds a value and its full flag
// depends on qse_pkg for the control and link structs

module qse_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  qse_pkg::t_ctl i_ctl,
    input  qse_pkg::t_link i_prev,
    input  qse_pkg::t_link i_next,
    output qse_pkg::t_link o_link
);

    logic            r_full;
    qse_pkg::t_value r_val;
    logic            n_full;
    qse_pkg::t_value n_val;
    logic            w_keep;

    // this slot stays put when it holds a value not above the new word
    assign w_keep = r_full && (r_val <= i_ctl.value);

    always_comb begin
        n_full = r_full;
        n_val  = r_val;
        if (i_ctl.shift) begin
            n_full = i_next.full;
            n_val  = i_next.val;
        end else if (i_ctl.insert && !w_keep) begin
            if (i_prev.keep) begin
                n_full = 1'b1;
                n_val  = i_ctl.value;
            end else begin
                // make room: take the left neighbor's value
                n_full = i_prev.full;
                n_val  = i_prev.val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
        r_val <= n_val;
    end

    assign o_link.full = r_full;
    assign o_link.keep = w_keep;
    assign o_link.val  = r_val;

endmodule

>>> tb/quicksort_engine_tb.sv
`timescale 1ns / 1ps
// quicksort_engine_tb: self-checking bench for quicksort_engine, sets of signed words in,
// ascending runs out; depends on qse_pkg, qse_stream_if and the quicksort_engine rtl

module quicksort_engine_tb;

    localparam int unsigned     DEPTH       = 64;
    localparam int unsigned     RAND_WORDS  = 320;
    localparam int unsigned     CYCLE_LIMIT = 200000;
    localparam int unsigned     DRAIN_TAIL  = 2 * DEPTH + 20;
    localparam qse_pkg::t_value VAL_MIN     = qse_pkg::t_value'(32'h8000_0000);
    localparam qse_pkg::t_value VAL_MAX     = qse_pkg::t_value'(32'h7fff_ffff);

    typedef enum int unsigned {
        FILL_RANDOM,
        FILL_ASCENDING,
        FILL_DESCENDING,
        FILL_EQUAL,
        FILL_FEW
    } t_set_shape;

    logic clk;
    logic rst_n;

    qse_stream_if #(.t_word(qse_pkg::t_in_word))  in_if ();
    qse_stream_if #(.t_word(qse_pkg::t_out_word)) out_if ();

    quicksort_engine #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    qse_pkg::t_in_word  pend_words[$];
    qse_pkg::t_out_word sorted_words_due[$];
    qse_pkg::t_value    set_vals[DEPTH];
    int unsigned set_len     = 0;
    int unsigned words_taken = 0;
    int unsigned total_words = 0;
    int unsigned mismatches  = 0;
    int unsigned cycles      = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle percentages per phase: sender-light, then receiver-light, then none
    function automatic int unsigned idle_pct(bit for_sender);
        if (words_taken < total_words / 3) begin
            return for_sender ? 13 : 70;
        end else if (words_taken < 2 * total_words / 3) begin
            return for_sender ? 70 : 13;
        end
        return 0;
    endfunction

    // first-element pivot, hole filling from both ends, explicit range stack
    function automatic void sort_loaded_set();
        int              lo_stack[$];
        int              hi_stack[$];
        int              lo;
        int              hi;
        int              l;
        int              r;
        qse_pkg::t_value pivot;
        if (set_len < 2) return;
        lo_stack.push_back(0);
        hi_stack.push_back(set_len - 1);
        while (lo_stack.size() > 0) begin
            lo = lo_stack.pop_back();
            hi = hi_stack.pop_back();
            l = lo;
            r = hi;
            pivot = set_vals[l];
            do begin
                while (l < r && set_vals[r] > pivot) r--;
                if (l < r) begin
                    set_vals[l] = set_vals[r];
                    l++;
                end
                while (l < r && set_vals[l] < pivot) l++;
                if (l < r) begin
                    set_vals[r] = set_vals[l];
                    r--;
                end
            end while (l != r);
            set_vals[l] = pivot;
            if (l + 1 < hi) begin
                lo_stack.push_back(l + 1);
                hi_stack.push_back(hi);
            end
            if (l > lo + 1) begin
                lo_stack.push_back(lo);
                hi_stack.push_back(l - 1);
            end
        end
    endfunction

    // store the word; a marked word or a full store closes the set
    function automatic void load_word(qse_pkg::t_in_word w);
        qse_pkg::t_out_word o;
        set_vals[set_len] = w.value;
        set_len++;
        if (w.is_last || set_len == DEPTH) begin
            sort_loaded_set();
            for (int unsigned i = 0; i < set_len; i++) begin
                o.value_res   = set_vals[i];
                o.is_last_res = (i + 1 == set_len);
                sorted_words_due.push_back(o);
            end
            set_len = 0;
        end
    endfunction

    function automatic void queue_word(qse_pkg::t_value v, bit end_bit);
        pend_words.push_back(qse_pkg::t_in_word'{value: v, is_last: end_bit});
    endfunction

    function automatic void queue_set(int unsigned n, t_set_shape shape, bit end_bit);
        qse_pkg::t_value vals[$];
        qse_pkg::t_value base;
        base = qse_pkg::t_value'($urandom);
        for (int unsigned i = 0; i < n; i++) begin
            case (shape)
                FILL_EQUAL: begin
                    vals.push_back(base);
                end
                FILL_FEW: begin
                    vals.push_back(base + qse_pkg::t_value'($urandom_range(2)));
                end
                default: begin
                    case ($urandom_range(15))
                        0:       vals.push_back(VAL_MIN);
                        1:       vals.push_back(VAL_MAX);
                        default: vals.push_back(qse_pkg::t_value'($urandom));
                    endcase
                end
            endcase
        end
        if (shape == FILL_ASCENDING) begin
            vals.sort();
        end else if (shape == FILL_DESCENDING) begin
            vals.rsort();
        end
        for (int unsigned i = 0; i < n; i++) begin
            queue_word(vals[i], (i == n - 1) ? end_bit : 1'b0);
        end
    endfunction

    // driver: offers the next pending word once the current one is taken
    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                load_word(in_if.data);
                words_taken++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (pend_words.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
                    in_if.valid <= 1'b1;
                    in_if.data  <= pend_words.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: every word out is checked against the oldest one due
    always @(posedge clk) begin
        qse_pkg::t_out_word exp_word;
        qse_pkg::t_out_word got_word;
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got_word = out_if.data;
                if (sorted_words_due.size() == 0) begin
                    $error("unexpected word: value_res %0d is_last_res %0b",
                           got_word.value_res, got_word.is_last_res);
                    mismatches++;
                end else begin
                    exp_word = sorted_words_due.pop_front();
                    if (got_word.value_res !== exp_word.value_res) begin
                        $error("value_res: expected %0d, got %0d",
                               exp_word.value_res, got_word.value_res);
                        mismatches++;
                    end
                    if (got_word.is_last_res !== exp_word.is_last_res) begin
                        $error("is_last_res: expected %0b, got %0b",
                               exp_word.is_last_res, got_word.is_last_res);
                        mismatches++;
                    end
                end
            end
            out_if.ready <= ($urandom_range(99) >= idle_pct(1'b0));
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int unsigned rand_count;
        int unsigned n;
        int unsigned pick;
        t_set_shape  shape;

        rst_n = 1'b0;

        // directed: extremes, tiny sets, equal values, presorted runs
        queue_word(VAL_MIN, 1'b1);
        queue_word(VAL_MAX, 1'b1);
        queue_word(VAL_MAX, 1'b0);
        queue_word(VAL_MIN, 1'b1);
        queue_word(0, 1'b0);
        queue_word(-1, 1'b0);
        queue_word(1, 1'b1);
        queue_word(7, 1'b0);
        queue_word(7, 1'b0);
        queue_word(7, 1'b1);
        queue_word(qse_pkg::t_value'(32'h5555_5555), 1'b0);
        queue_word(qse_pkg::t_value'(32'haaaa_aaaa), 1'b0);
        queue_word(3, 1'b0);
        queue_word(-3, 1'b0);
        queue_word(VAL_MAX - 1, 1'b0);
        queue_word(VAL_MIN + 1, 1'b1);
        queue_word(-2, 1'b0);
        queue_word(-1, 1'b0);
        queue_word(0, 1'b0);
        queue_word(1, 1'b1);
        queue_word(10, 1'b0);
        queue_word(5, 1'b0);
        queue_word(0, 1'b0);
        queue_word(-5, 1'b1);

        // full store with no marked word: the 64th word must close the set
        queue_set(DEPTH, FILL_RANDOM, 1'b0);
        rand_count = DEPTH;
        while (rand_count < RAND_WORDS) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(13, DEPTH) : $urandom_range(1, 12);
            pick = $urandom_range(9);
            shape = (pick < 6) ? FILL_RANDOM : t_set_shape'(pick - 5);
            queue_set(n, shape, (n == DEPTH) ? 1'($urandom_range(1)) : 1'b1);
            rand_count += n;
        end
        total_words = pend_words.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pend_words.size() > 0 || in_if.valid) @(posedge clk);
        while (sorted_words_due.size() > 0) @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (mismatches == 0 && sorted_words_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
